### rtl/core/ecd_pkg.sv
`default_nettype none
package ecd_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES = 64;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES);
  localparam logic REG_DIRECTED = 1'b0;
  localparam logic REG_VCOUNT = 1'b1;
  typedef logic [VW-1:0] vertex_t;
  typedef logic [EW-1:0] edge_idx_t;
  typedef logic [5:0] count_t;
endpackage
`default_nettype wire

### rtl/core/ecd_if.sv
`default_nettype none
interface ecd_edge_if;
  import ecd_pkg::*;
  logic valid;
  logic ready;
  vertex_t edge_source;
  vertex_t edge_target;
  logic last_edge;
  modport source (output valid, edge_source, edge_target, last_edge, input ready);
  modport sink (input valid, edge_source, edge_target, last_edge, output ready);
endinterface

interface ecd_result_if;
  import ecd_pkg::*;
  logic valid;
  logic ready;
  edge_idx_t edge_number;
  count_t in_count;
  count_t out_count;
  logic signed [15:0] degree_ratio;
  logic ratio_undefined;
  logic last_result;
  modport source (output valid, edge_number, in_count, out_count, degree_ratio,
                  ratio_undefined, last_result, input ready);
  modport sink (input valid, edge_number, in_count, out_count, degree_ratio,
                ratio_undefined, last_result, output ready);
endinterface
`default_nettype wire

### rtl/core/edge_convergence_degree.sv
// Channel  | Direction | Request
// edges    | in        | one edge: source, target, last flag
// results  | out       | one edge result: counts, Q1.15 ratio, flags
// cfg      | in        | register write, index 0 directed, 1 vertex count
// Edges are taken while loading. The final edge starts the search: a counter
// clear over every loaded edge, then per root a clear of every vertex level and a
// seed step, then for each queued vertex a scan of every stored edge. Each result
// is then computed by a divider that gives one quotient bit per cycle, skipped
// when both counts are zero.
// Reset is synchronous; a stalled result holds the block until it is taken.
`default_nettype none
module edge_convergence_degree (
  input wire logic clk,
  input wire logic rst,
  ecd_edge_if.sink edges,
  ecd_result_if.source results,
  input wire logic cfg_write,
  input wire logic cfg_index,
  input wire logic [5:0] cfg_data
);
  import ecd_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0, S_CCLR = 4'd1, S_LCLR = 4'd2, S_ROOT = 4'd3,
    S_POP = 4'd4, S_QWAIT = 4'd5, S_LWAIT = 4'd6, S_EDGE = 4'd7, S_EWAIT = 4'd8,
    S_NBW = 4'd9, S_CNT = 4'd10, S_ORD = 4'd11, S_OWAIT = 4'd12, S_DIV = 4'd13,
    S_FIN = 4'd14, S_EMIT = 4'd15;

  logic [3:0] state;
  logic directed;
  logic [5:0] vcount;
  logic [EW:0] loaded, e, idx;
  logic [VW:0] head, tail, root, roots;
  logic pass;
  vertex_t a, nb;
  logic [5:0] nxt;
  logic to_in;

  logic [2*VW-1:0] edge_mem [MAX_EDGES];
  logic [2*VW-1:0] edge_q;
  logic [11:0] cnt_mem [MAX_EDGES];
  logic [11:0] cnt_q;
  logic [5:0] lvl_mem [MAX_VERTICES];
  logic [5:0] lvl_q;
  vertex_t q_mem [MAX_VERTICES];
  vertex_t q_q;

  logic edge_we, cnt_we, lvl_we, q_we;
  logic [11:0] cnt_wd;
  vertex_t lvl_wa, lvl_ra, q_wa;
  logic [5:0] lvl_wd;
  vertex_t q_wd;

  vertex_t ev_s, ev_t, ev_nb;
  logic ev_match, ev_in;

  count_t ic, oc;
  logic [6:0] den, rem;
  logic [20:0] quo;
  logic [4:0] dcnt;
  logic [7:0] trial;
  logic [15:0] ratio;
  logic [15:0] qsat;

  assign roots = (vcount > 6'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES) : (VW+1)'(vcount);
  assign edges.ready = (state == S_LOAD);
  assign edge_we = edges.valid && edges.ready && (loaded < (EW+1)'(MAX_EDGES));

  assign ev_s = edge_q[2*VW-1:VW];
  assign ev_t = edge_q[VW-1:0];
  always_comb begin
    ev_match = 1'b0;
    ev_nb = ev_t;
    ev_in = 1'b1;
    if (directed) begin
      ev_in = !pass;
      ev_match = pass ? (ev_t == a) : (ev_s == a);
      ev_nb = pass ? ev_s : ev_t;
    end else begin
      if (ev_s == a) begin
        ev_match = 1'b1;
        ev_nb = ev_t;
      end else if (ev_t == a) begin
        ev_match = 1'b1;
        ev_nb = ev_s;
      end
      ev_in = (a < ev_nb);
    end
  end

  always_comb begin
    cnt_we = (state == S_CCLR) || (state == S_CNT);
    cnt_wd = '0;
    if (state == S_CNT) begin
      cnt_wd = cnt_q;
      if (to_in) cnt_wd[11:6] = cnt_q[11:6] + 6'd1;
      else cnt_wd[5:0] = cnt_q[5:0] + 6'd1;
    end
    lvl_we = 1'b0;
    lvl_wa = idx[VW-1:0];
    lvl_wd = '0;
    q_we = 1'b0;
    q_wa = '0;
    q_wd = root[VW-1:0];
    case (state)
      S_LCLR: lvl_we = 1'b1;
      S_ROOT: begin
        lvl_we = 1'b1;
        lvl_wa = root[VW-1:0];
        lvl_wd = 6'd1;
        q_we = 1'b1;
      end
      S_NBW: begin
        if (lvl_q == 6'd0) begin
          lvl_we = 1'b1;
          lvl_wa = nb;
          lvl_wd = nxt;
          q_we = (tail < (VW+1)'(MAX_VERTICES));
          q_wa = tail[VW-1:0];
          q_wd = nb;
        end
      end
      default: ;
    endcase
    lvl_ra = (state == S_QWAIT) ? q_q : ev_nb;
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[loaded[EW-1:0]] <= {edges.edge_source, edges.edge_target};
    edge_q <= edge_mem[e[EW-1:0]];
    if (cnt_we) cnt_mem[(state == S_CCLR) ? idx[EW-1:0] : e[EW-1:0]] <= cnt_wd;
    cnt_q <= cnt_mem[e[EW-1:0]];
    if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
    lvl_q <= lvl_mem[lvl_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_q <= q_mem[head[VW-1:0]];
  end

  assign trial = {rem, quo[20]};
  always_comb begin
    qsat = (quo > 21'd32767) ? 16'd32767 : quo[15:0];
    ratio = (directed && (ic < oc)) ? (16'd0 - qsat) : qsat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      directed <= 1'b1;
      vcount <= 6'd32;
      loaded <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_DIRECTED) directed <= cfg_data[0];
        else vcount <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (edges.valid) begin
            if (edge_we) loaded <= loaded + 1'b1;
            if (edges.last_edge) begin
              idx <= '0;
              state <= S_CCLR;
            end
          end
        end
        S_CCLR: begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 >= loaded) begin
            pass <= 1'b0;
            root <= '0;
            idx <= '0;
            e <= '0;
            state <= (roots == '0) ? S_ORD : S_LCLR;
          end
        end
        S_LCLR: begin
          idx <= idx + 1'b1;
          if (idx == (EW+1)'(MAX_VERTICES - 1)) state <= S_ROOT;
        end
        S_ROOT: begin
          head <= '0;
          tail <= (VW+1)'(1);
          state <= S_POP;
        end
        S_POP: begin
          idx <= '0;
          if (head != tail) state <= S_QWAIT;
          else if (root + 1'b1 < roots) begin
            root <= root + 1'b1;
            state <= S_LCLR;
          end else if (directed && !pass) begin
            pass <= 1'b1;
            root <= '0;
            state <= S_LCLR;
          end else begin
            e <= '0;
            state <= S_ORD;
          end
        end
        S_QWAIT: begin
          a <= q_q;
          head <= head + 1'b1;
          state <= S_LWAIT;
        end
        S_LWAIT: begin
          nxt <= lvl_q + 6'd1;
          e <= '0;
          state <= S_EDGE;
        end
        S_EDGE: state <= (e == loaded) ? S_POP : S_EWAIT;
        S_EWAIT: begin
          nb <= ev_nb;
          to_in <= ev_in;
          if (ev_match) state <= S_NBW;
          else begin
            e <= e + 1'b1;
            state <= S_EDGE;
          end
        end
        S_NBW: begin
          if (lvl_q == 6'd0) begin
            if (tail < (VW+1)'(MAX_VERTICES)) tail <= tail + 1'b1;
            state <= S_CNT;
          end else if (lvl_q == nxt) state <= S_CNT;
          else begin
            e <= e + 1'b1;
            state <= S_EDGE;
          end
        end
        S_CNT: begin
          e <= e + 1'b1;
          state <= S_EDGE;
        end
        S_ORD: state <= S_OWAIT;
        S_OWAIT: begin
          ic <= cnt_q[11:6];
          oc <= cnt_q[5:0];
          den <= {1'b0, cnt_q[11:6]} + {1'b0, cnt_q[5:0]};
          quo <= {((cnt_q[11:6] > cnt_q[5:0]) ? (cnt_q[11:6] - cnt_q[5:0])
                                              : (cnt_q[5:0] - cnt_q[11:6])), 15'd0};
          rem <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (den == 7'd0) state <= S_FIN;
          else begin
            if (trial >= {1'b0, den}) begin
              rem <= 7'(trial - {1'b0, den});
              quo <= {quo[19:0], 1'b1};
            end else begin
              rem <= trial[6:0];
              quo <= {quo[19:0], 1'b0};
            end
            dcnt <= dcnt + 5'd1;
            if (dcnt == 5'd20) state <= S_FIN;
          end
        end
        S_FIN: begin
          results.valid <= 1'b1;
          results.edge_number <= e[EW-1:0];
          results.in_count <= ic;
          results.out_count <= oc;
          results.ratio_undefined <= (den == 7'd0);
          results.degree_ratio <= (den == 7'd0) ? 16'sd0 : $signed(ratio);
          results.last_result <= (e + 1'b1 == loaded);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            if (e + 1'b1 == loaded) begin
              loaded <= '0;
              state <= S_LOAD;
            end else begin
              e <= e + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_valid_emit: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (state == S_EMIT)) else $error("result valid outside emit");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(edges.ready && results.valid)) else $error("load while result pending");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (head <= tail && tail <= (VW+1)'(MAX_VERTICES)))
    else $error("queue pointers out of order");
  a_loaded: assert property (@(posedge clk) disable iff (rst)
    loaded <= (EW+1)'(MAX_EDGES)) else $error("edge count overflow");
endmodule
`default_nettype wire
